@@ rtl/core/dttu_pkg.sv @@
// Shared types and constants of the date-time text to Unix seconds converter.
// No dependencies; every other file but dttu_if refers to this package.
package dttu_pkg;

  // Depth of the job queue between the character parser and the converter
  localparam int unsigned FIFO_DEPTH = 2;

  // Calendar constants
  localparam int unsigned YEAR_MIN      = 1970;
  localparam int unsigned YEAR_MAX      = 2199;
  localparam int unsigned DAYS_PER_YEAR = 365;
  localparam int unsigned DAYS_PER_ERA  = 146097;
  localparam int unsigned EPOCH_DAYS    = 719468;
  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_MIN  = 60;

  // One finished string, handed from the parser to the converter
  typedef struct packed {
    logic        ok;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } job_t;

  // Converter sequencer
  typedef enum logic [1:0] {
    B_IDLE,
    B_DAYS,
    B_SCALE,
    B_OUT
  } back_state_e;

endpackage

@@ rtl/core/dttu_if.sv @@
// Handshake channels of the converter: character input and seconds output.
// Depends on nothing; used by the top level, the parser and the converter.
interface dttu_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       first_char;

  modport source (output valid, output text_char, output first_char, input ready);
  modport sink   (input valid, input text_char, input first_char, output ready);
endinterface

interface dttu_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] unix_seconds;
  logic        parse_ok;

  modport source (output valid, output unix_seconds, output parse_ok, input ready);
  modport sink   (input valid, input unix_seconds, input parse_ok, output ready);
endinterface

@@ rtl/core/datetime_text_to_unix_seconds.sv @@
// Top level of the date-time text to Unix seconds converter.
// Instantiates dttu_front, dttu_fifo and dttu_back; uses dttu_pkg and dttu_if.
//
// Feed the characters of a "YYYY-MM-DD HH:MM:SS" UTC string one beat at a
// time on char_i, with first_char set on the first one. The parser takes one
// character per cycle while the job queue has room; after the nineteenth
// character (or a NUL before it) one result beat appears on res_o carrying
// seconds since 1970-01-01 modulo 2^32 and parse_ok, or zero and not ok when
// the format or a field range is wrong. Characters past the nineteenth and
// characters with no string open are dropped. The converter steps through
// load, day count, scale by 86400 and present for each string, waiting in
// present through any output stall; its sequencer sets the result rate, and
// the FifoDepth-job queue lets the parser keep taking characters meanwhile.
module datetime_text_to_unix_seconds #(
  parameter int unsigned FifoDepth = dttu_pkg::FIFO_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dttu_char_if.sink     char_i,
  dttu_result_if.source res_o
);

  logic           push, full, pop, empty;
  dttu_pkg::job_t job_in, job_out;

  dttu_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_i),
    .full_i (full),
    .push_o (push),
    .job_o  (job_in)
  );

  dttu_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (job_out)
  );

  dttu_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .job_i   (job_out),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

@@ rtl/core/dttu_front.sv @@
// Character parser: checks the text format, gathers the date and time fields
// and pushes one job per finished string. Depends on dttu_pkg and dttu_if.
module dttu_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  dttu_char_if.sink           char_i,
  input  logic                full_i,
  output logic                push_o,
  output dttu_pkg::job_t      job_o
);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [4:0] POS_DASH_YM  = 5'd4;
  localparam logic [4:0] POS_DASH_MD  = 5'd7;
  localparam logic [4:0] POS_SPACE    = 5'd10;
  localparam logic [4:0] POS_COLON_HM = 5'd13;
  localparam logic [4:0] POS_COLON_MS = 5'd16;
  localparam logic [4:0] POS_YEAR_END = 5'd3;
  localparam logic [4:0] POS_MON_END  = 5'd6;
  localparam logic [4:0] POS_DAY_END  = 5'd9;
  localparam logic [4:0] POS_HOUR_END = 5'd12;
  localparam logic [4:0] POS_MIN_END  = 5'd15;
  localparam logic [4:0] POS_LAST     = 5'd18;
  localparam logic [4:0] POS_DONE     = 5'd19;

  localparam logic [13:0] YEAR_LO = 14'(dttu_pkg::YEAR_MIN);
  localparam logic [13:0] YEAR_HI = 14'(dttu_pkg::YEAR_MAX);

  // Append a decimal digit, keeping the field width
  function automatic logic [13:0] add_digit14(logic [13:0] v, logic [3:0] d);
    logic [17:0] t;
    t = {4'd0, v} * 18'd10 + {14'd0, d};
    return t[13:0];
  endfunction

  function automatic logic [6:0] add_digit7(logic [6:0] v, logic [3:0] d);
    logic [10:0] t;
    t = {4'd0, v} * 11'd10 + {7'd0, d};
    return t[6:0];
  endfunction

  logic [4:0]  pos_q, pos_d, p;
  logic        err_q, err_d;
  logic        done_q, done_d;
  logic [13:0] year_q, year_d;
  logic [6:0]  mon_q, mon_d, day_q, day_d, hour_q, hour_d;
  logic [6:0]  min_q, min_d, sec_q, sec_d;
  logic        accept;
  logic [7:0]  c;
  logic [3:0]  digit;
  logic        range_ok;

  assign char_i.ready = !full_i;
  assign accept       = char_i.valid && char_i.ready;
  assign c            = char_i.text_char;
  assign digit        = 4'(c - CH_ZERO);

  // Parse one character
  always_comb begin
    pos_d    = pos_q;
    err_d    = err_q;
    done_d   = done_q;
    year_d   = year_q;
    mon_d    = mon_q;
    day_d    = day_q;
    hour_d   = hour_q;
    min_d    = min_q;
    sec_d    = sec_q;
    push_o   = 1'b0;
    p        = pos_q;
    range_ok = 1'b0;
    job_o    = '0;

    if (accept && (char_i.first_char || !done_q)) begin
      // A start flag drops whatever string was in progress
      if (char_i.first_char) begin
        p      = '0;
        err_d  = 1'b0;
        year_d = '0;
        mon_d  = '0;
        day_d  = '0;
        hour_d = '0;
        min_d  = '0;
        sec_d  = '0;
      end
      done_d = 1'b0;

      if (c == CH_NUL) begin
        // Early end of string: report not ok and go idle
        done_d = 1'b1;
        pos_d  = p;
        push_o = 1'b1;
      end else begin
        case (p) inside
          POS_DASH_YM, POS_DASH_MD: begin
            if (c != CH_DASH) err_d = 1'b1;
          end
          POS_COLON_HM, POS_COLON_MS: begin
            if (c != CH_COLON) err_d = 1'b1;
          end
          POS_SPACE: begin
          end
          default: begin
            if (c < CH_ZERO || c > CH_NINE) begin
              err_d = 1'b1;
            end else if (p <= POS_YEAR_END) begin
              year_d = add_digit14(year_d, digit);
            end else if (p <= POS_MON_END) begin
              mon_d = add_digit7(mon_d, digit);
            end else if (p <= POS_DAY_END) begin
              day_d = add_digit7(day_d, digit);
            end else if (p <= POS_HOUR_END) begin
              hour_d = add_digit7(hour_d, digit);
            end else if (p <= POS_MIN_END) begin
              min_d = add_digit7(min_d, digit);
            end else begin
              sec_d = add_digit7(sec_d, digit);
            end
          end
        endcase

        range_ok = !err_d
                && year_d >= YEAR_LO && year_d <= YEAR_HI
                && mon_d >= 7'd1 && mon_d <= 7'd12
                && day_d >= 7'd1 && day_d <= 7'd31
                && hour_d <= 7'd23 && min_d <= 7'd59 && sec_d <= 7'd60;

        if (p < POS_LAST) begin
          pos_d = p + 5'd1;
        end else begin
          // Last character: hand the string to the converter
          pos_d        = POS_DONE;
          done_d       = 1'b1;
          push_o       = 1'b1;
          job_o.ok     = range_ok;
          job_o.year   = year_d;
          job_o.month  = mon_d;
          job_o.day    = day_d;
          job_o.hour   = hour_d;
          job_o.minute = min_d;
          job_o.second = sec_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      err_q  <= 1'b0;
      done_q <= 1'b1;
      year_q <= '0;
      mon_q  <= '0;
      day_q  <= '0;
      hour_q <= '0;
      min_q  <= '0;
      sec_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      err_q  <= err_d;
      done_q <= done_d;
      year_q <= year_d;
      mon_q  <= mon_d;
      day_q  <= day_d;
      hour_q <= hour_d;
      min_q  <= min_d;
      sec_q  <= sec_d;
    end
  end

endmodule

@@ rtl/core/dttu_fifo.sv @@
// Short job queue between the parser and the converter.
// Depends on dttu_pkg for the job type.
module dttu_fifo #(
  parameter int unsigned Depth = dttu_pkg::FIFO_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dttu_pkg::job_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output dttu_pkg::job_t rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PTR_LAST = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CNT_FULL = CntW'(Depth);

  dttu_pkg::job_t      mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;

  assign full_o  = (cnt_q == CNT_FULL);
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= wdata_i;
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_FULL) else $error("job queue count out of range");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full job queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from empty job queue");
  a_ptr_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty_o || full_o) |-> (wr_ptr_q == rd_ptr_q))
    else $error("job queue pointers disagree with count");
`endif

endmodule

@@ rtl/core/dttu_back.sv @@
// Converter: turns one job into Unix seconds over a few steps and holds the
// result in an output register. Depends on dttu_pkg and dttu_if.
module dttu_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  dttu_pkg::job_t job_i,
  output logic           pop_o,
  dttu_result_if.source  res_o
);

  localparam logic [17:0] ERA4_ADJ =
    18'(4 * dttu_pkg::DAYS_PER_ERA - dttu_pkg::EPOCH_DAYS);
  localparam logic [17:0] ERA5_ADJ =
    18'(5 * dttu_pkg::DAYS_PER_ERA - dttu_pkg::EPOCH_DAYS);
  localparam logic [13:0] ERA5_START = 14'd2000;
  localparam logic [13:0] ERA4_BASE  = 14'd1600;
  localparam logic [13:0] ERA5_BASE  = 14'd2000;
  localparam logic [16:0] DAY_SECS   = 17'(dttu_pkg::SECS_PER_DAY);

  // Days before the start of a March-based month: (153 * mp + 2) / 5
  function automatic logic [8:0] month_start(logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  dttu_pkg::back_state_e state_q, state_d;
  dttu_pkg::job_t        job_q;
  logic [16:0]           days_q, tod_q;
  logic [31:0]           secs_q;
  logic                  ok_q;

  logic        job_ld, days_ld, secs_ld;
  logic        m_le2, era5;
  logic [13:0] yp, yoe_w;
  logic [8:0]  yoe;
  logic [1:0]  cent;
  logic [3:0]  mp;
  logic [8:0]  doy;
  logic [17:0] doe, days_w;
  logic [16:0] tod_w;
  logic [33:0] prod;
  logic [31:0] secs_w;

  // Civil date to day count; valid jobs have years 1969..2199 after the
  // March shift, so the era is four or five
  always_comb begin
    m_le2 = job_q.month <= 7'd2;
    yp    = job_q.year - {13'd0, m_le2};
    era5  = yp >= ERA5_START;
    yoe_w = yp - (era5 ? ERA5_BASE : ERA4_BASE);
    yoe   = yoe_w[8:0];
    if (yoe >= 9'd300)      cent = 2'd3;
    else if (yoe >= 9'd200) cent = 2'd2;
    else if (yoe >= 9'd100) cent = 2'd1;
    else                    cent = 2'd0;
    mp     = m_le2 ? 4'(job_q.month + 7'd9) : 4'(job_q.month - 7'd3);
    doy    = month_start(mp) + {2'd0, job_q.day} - 9'd1;
    doe    = {9'd0, yoe} * 18'(dttu_pkg::DAYS_PER_YEAR) + {11'd0, yoe[8:2]}
           - {16'd0, cent} + {9'd0, doy};
    days_w = doe + (era5 ? ERA5_ADJ : ERA4_ADJ);
    tod_w  = 17'(job_q.hour[4:0]) * 17'(dttu_pkg::SECS_PER_HOUR)
           + 17'(job_q.minute[5:0]) * 17'(dttu_pkg::SECS_PER_MIN)
           + 17'(job_q.second[5:0]);
  end

  // Scale to seconds, wrapping at 32 bits
  assign prod   = {17'd0, days_q} * {17'd0, DAY_SECS};
  assign secs_w = prod[31:0] + {15'd0, tod_q};

  // Sequencer
  always_comb begin
    state_d = state_q;
    job_ld  = 1'b0;
    days_ld = 1'b0;
    secs_ld = 1'b0;
    pop_o   = 1'b0;
    case (state_q)
      dttu_pkg::B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          job_ld  = 1'b1;
          state_d = dttu_pkg::B_DAYS;
        end
      end
      dttu_pkg::B_DAYS: begin
        days_ld = 1'b1;
        state_d = dttu_pkg::B_SCALE;
      end
      dttu_pkg::B_SCALE: begin
        secs_ld = 1'b1;
        state_d = dttu_pkg::B_OUT;
      end
      dttu_pkg::B_OUT: begin
        if (res_o.ready) state_d = dttu_pkg::B_IDLE;
      end
      default: state_d = dttu_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= dttu_pkg::B_IDLE;
    else         state_q <= state_d;
  end

  // Hold job, intermediate values and result
  always_ff @(posedge clk_i) begin
    if (job_ld) job_q <= job_i;
    if (days_ld) begin
      days_q <= days_w[16:0];
      tod_q  <= tod_w;
    end
    if (secs_ld) begin
      secs_q <= job_q.ok ? secs_w : '0;
      ok_q   <= job_q.ok;
    end
  end

  assign res_o.valid        = (state_q == dttu_pkg::B_OUT);
  assign res_o.unix_seconds = secs_q;
  assign res_o.parse_ok     = ok_q;

`ifndef ASSERT_OFF
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == dttu_pkg::B_DAYS)) else $error("pop outside idle");
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |=> (res_o.valid && $stable(secs_q)))
    else $error("result dropped while stalled");
  a_zero_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.parse_ok) |-> (res_o.unix_seconds == '0))
    else $error("nonzero seconds on failed parse");
`endif

endmodule

@@ sim/tb_datetime_text_to_unix_seconds.sv @@
// Testbench for datetime_text_to_unix_seconds: streams timestamp text and checks seconds.
// Depends on dttu_pkg, dttu_char_if/dttu_result_if and the top level; self-checking.
// Uses a small scoreboard class with its own copy of the parser state.
`timescale 1ns / 1ps

localparam logic [7:0] CH_NUL   = 8'h00;
localparam logic [7:0] CH_DASH  = 8'h2D;
localparam logic [7:0] CH_SLASH = 8'h2F;
localparam logic [7:0] CH_ZERO  = 8'h30;
localparam logic [7:0] CH_NINE  = 8'h39;
localparam logic [7:0] CH_COLON = 8'h3A;
localparam logic [7:0] CH_SPACE = 8'h20;
localparam logic [7:0] CH_T     = 8'h54;
localparam logic [7:0] CH_LOW_A = 8'h61;

localparam int unsigned POS_DASH_A  = 4;
localparam int unsigned POS_DASH_B  = 7;
localparam int unsigned POS_GAP     = 10;
localparam int unsigned POS_COLON_A = 13;
localparam int unsigned POS_COLON_B = 16;
localparam int unsigned POS_LAST    = 18;
localparam int unsigned TEXT_LEN    = 19;

typedef struct packed {
  logic [31:0] secs;
  logic        ok;
} stamp_t;

class epoch_scoreboard;
  logic [4:0]  char_pos;
  bit          fmt_err;
  bit          idle;
  logic [13:0] year;
  logic [6:0]  month;
  logic [6:0]  day;
  logic [6:0]  hour;
  logic [6:0]  minute;
  logic [6:0]  second;
  stamp_t      stamp_q[$];
  int unsigned mismatches;
  int unsigned checked;
  int unsigned good_stamps;
  int unsigned predicted;

  function new();
    clear_fields();
    idle        = 1;
    mismatches  = 0;
    checked     = 0;
    good_stamps = 0;
    predicted   = 0;
  endfunction

  function void clear_fields();
    char_pos = '0;
    fmt_err  = 0;
    year     = '0;
    month    = '0;
    day      = '0;
    hour     = '0;
    minute   = '0;
    second   = '0;
  endfunction

  // Civil date to days since the epoch, then scale and add time of day
  function logic [31:0] epoch_seconds();
    longint unsigned y, m, d, era, yoe, mp, doy, doe, days, tod;
    y = year;
    m = month;
    d = day;
    if (m <= 2) y = y - 1;
    era  = y / 400;
    yoe  = y - era * 400;
    mp   = (m > 2) ? (m - 3) : (m + 9);
    doy  = (153 * mp + 2) / 5 + d - 1;
    doe  = yoe * dttu_pkg::DAYS_PER_YEAR + yoe / 4 - yoe / 100 + doy;
    days = era * dttu_pkg::DAYS_PER_ERA + doe - dttu_pkg::EPOCH_DAYS;
    tod  = longint'(hour) * dttu_pkg::SECS_PER_HOUR
         + longint'(minute) * dttu_pkg::SECS_PER_MIN + second;
    return 32'(days * dttu_pkg::SECS_PER_DAY + tod);
  endfunction

  function void push_stamp(logic [31:0] secs, logic ok);
    stamp_t s;
    s.secs = secs;
    s.ok   = ok;
    stamp_q.push_back(s);
    predicted++;
  endfunction

  // Note one accepted character and queue the stamp it finishes, if any
  function void note_char(logic [7:0] c, bit first);
    logic [3:0] dgt;
    int unsigned p;
    bit fine;
    if (first) begin
      clear_fields();
      idle = 0;
    end else if (idle) begin
      return;
    end
    p = char_pos;
    if (c == CH_NUL) begin
      idle = 1;
      push_stamp('0, 1'b0);
      return;
    end
    if (p == POS_DASH_A || p == POS_DASH_B) begin
      if (c != CH_DASH) fmt_err = 1;
    end else if (p == POS_COLON_A || p == POS_COLON_B) begin
      if (c != CH_COLON) fmt_err = 1;
    end else if (p == POS_GAP) begin
      // any non-NUL character separates date and time
    end else if (c < CH_ZERO || c > CH_NINE) begin
      fmt_err = 1;
    end else begin
      dgt = 4'(c - CH_ZERO);
      if (p <= 3)       year   = 14'(year * 10 + dgt);
      else if (p <= 6)  month  = 7'(month * 10 + dgt);
      else if (p <= 9)  day    = 7'(day * 10 + dgt);
      else if (p <= 12) hour   = 7'(hour * 10 + dgt);
      else if (p <= 15) minute = 7'(minute * 10 + dgt);
      else              second = 7'(second * 10 + dgt);
    end
    if (p < POS_LAST) begin
      char_pos = 5'(p + 1);
      return;
    end
    char_pos = 5'(TEXT_LEN);
    idle = 1;
    fine = !fmt_err
        && year >= dttu_pkg::YEAR_MIN && year <= dttu_pkg::YEAR_MAX
        && month >= 1 && month <= 12 && day >= 1 && day <= 31
        && hour <= 23 && minute <= 59 && second <= 60;
    push_stamp(fine ? epoch_seconds() : 32'd0, fine);
  endfunction

  function void report(string what, stamp_t want, logic [31:0] secs, logic ok);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t MISMATCH %s: expected secs=%0d ok=%0b, got secs=%0d ok=%0b",
               $realtime, what, want.secs, want.ok, secs, ok);
  endfunction

  // Compare one result beat with the oldest pending stamp
  function void check_result(logic [31:0] secs, logic ok);
    stamp_t want;
    if (stamp_q.size() == 0) begin
      want = '0;
      report("unexpected result", want, secs, ok);
      return;
    end
    want = stamp_q.pop_front();
    checked++;
    if (ok === 1'b1) good_stamps++;
    if (want.secs !== secs || want.ok !== ok) report("result", want, secs, ok);
  endfunction

  function void flush_missing();
    stamp_t want;
    while (stamp_q.size() != 0) begin
      want = stamp_q.pop_front();
      report("missing result", want, 'x, 'x);
    end
  endfunction
endclass

module tb_datetime_text_to_unix_seconds;
  localparam int unsigned TOTAL_CHARS    = 1200;
  localparam int unsigned TAIL_CYCLES    = 16;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  logic clk_i;
  logic rst_ni;

  dttu_char_if   char_if ();
  dttu_result_if res_if ();

  datetime_text_to_unix_seconds uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_if),
    .res_o  (res_if)
  );

  epoch_scoreboard sb = new();

  byte unsigned line_buf [TEXT_LEN];
  int unsigned  chars_sent = 0;
  int unsigned  strings_sent = 0;
  int unsigned  burst_left = 0;
  int unsigned  rx_mode = 0;
  int unsigned  rx_mode_left = 0;
  int unsigned  rx_stall_run = 0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Bursty sender: drop valid for a random gap at the end of each burst
  task automatic pace_sender();
    if (burst_left == 0) begin
      char_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
    end
    burst_left--;
  endtask

  // Drive one character beat and hold it until accepted
  task automatic push_char(logic [7:0] c, bit first);
    pace_sender();
    char_if.valid      <= 1'b1;
    char_if.text_char  <= c;
    char_if.first_char <= first;
    do @(posedge clk_i); while (!char_if.ready);
    sb.note_char(c, first);
    chars_sent++;
  endtask

  // Hold the sender until every pending stamp has come out
  task automatic drain_results();
    char_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.stamp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic put_num(int unsigned at, int unsigned width, int unsigned val);
    for (int i = int'(width) - 1; i >= 0; i--) begin
      line_buf[at + i] = 8'(CH_ZERO + val % 10);
      val = val / 10;
    end
  endtask

  task automatic fill_line(int unsigned yr, int unsigned mo, int unsigned dy,
                           int unsigned hr, int unsigned mi, int unsigned se,
                           logic [7:0] gap_ch);
    put_num(0, 4, yr);
    line_buf[POS_DASH_A] = CH_DASH;
    put_num(5, 2, mo);
    line_buf[POS_DASH_B] = CH_DASH;
    put_num(8, 2, dy);
    line_buf[POS_GAP] = gap_ch;
    put_num(11, 2, hr);
    line_buf[POS_COLON_A] = CH_COLON;
    put_num(14, 2, mi);
    line_buf[POS_COLON_B] = CH_COLON;
    put_num(17, 2, se);
  endtask

  // Send the first len characters of the line as a new string
  task automatic send_line(int unsigned len);
    for (int unsigned i = 0; i < len; i++) push_char(line_buf[i], i == 0);
    strings_sent++;
  endtask

  // Mostly legal fields, now and then any two or four digits
  task automatic fill_random_line();
    int unsigned yr, mo, dy, hr, mi, se;
    yr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 9999)
                                     : $urandom_range(dttu_pkg::YEAR_MIN, dttu_pkg::YEAR_MAX);
    mo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
    dy = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 31);
    hr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23);
    mi = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
    se = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 60);
    // lean on the range edges now and then
    if ($urandom_range(0, 7) == 0) yr = $urandom_range(0, 1) ? dttu_pkg::YEAR_MIN
                                                           : dttu_pkg::YEAR_MAX;
    if ($urandom_range(0, 7) == 0) mo = $urandom_range(0, 1) ? 1 : 2;
    if ($urandom_range(0, 7) == 0) dy = $urandom_range(0, 1) ? 31 : 29;
    fill_line(yr, mo, dy, hr, mi, se,
              $urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(1, 255)));
  endtask

  // Result side: check accepted beats, then pick the next ready value
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready)
      sb.check_result(res_if.unix_seconds, res_if.parse_ok);
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(20, 200);
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      0: res_if.ready <= 1'b1;
      1: res_if.ready <= ($urandom_range(0, 3) != 0);
      2: res_if.ready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (rx_stall_run > 0) begin
          rx_stall_run--;
          res_if.ready <= 1'b0;
        end else begin
          rx_stall_run = $urandom_range(5, 30);
          res_if.ready <= 1'b1;
        end
      end
    endcase
  end

  // Watchdog: end the run when no beat moves for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (char_if.valid && char_if.ready) || (res_if.valid && res_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Watchdog expired after %0d idle cycles, %0d stamps still pending",
             WATCHDOG_LIMIT, sb.stamp_q.size());
    $display("== FAIL ==");
    $finish;
  end

  // Main stimulus
  initial begin
    int unsigned kind;
    int unsigned len;
    char_if.valid      = 1'b0;
    char_if.text_char  = '0;
    char_if.first_char = 1'b0;
    res_if.ready       = 1'b0;
    rst_ni             = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Idle block ignores characters until a string opens
    push_char(8'hFF, 1'b0);
    push_char(CH_ZERO, 1'b0);

    // Epoch, upper extremes, leap day, leap-month and January paths
    fill_line(1970, 1, 1, 0, 0, 0, CH_SPACE);
    send_line(TEXT_LEN);
    fill_line(2199, 12, 31, 23, 59, 60, CH_T);
    send_line(TEXT_LEN);
    fill_line(2000, 2, 29, 12, 34, 56, CH_T);
    send_line(TEXT_LEN);
    fill_line(2024, 1, 31, 9, 8, 7, 8'hFF);
    send_line(TEXT_LEN);
    // day past month end rolls over
    fill_line(2023, 2, 31, 1, 2, 3, CH_SPACE);
    send_line(TEXT_LEN);

    // Each field just out of range
    fill_line(1969, 12, 31, 23, 59, 59, CH_SPACE);
    send_line(TEXT_LEN);
    fill_line(2200, 1, 1, 0, 0, 0, CH_SPACE);
    send_line(TEXT_LEN);
    fill_line(2001, 0, 10, 0, 0, 0, CH_SPACE);
    send_line(TEXT_LEN);
    fill_line(2001, 13, 10, 0, 0, 0, CH_SPACE);
    send_line(TEXT_LEN);
    fill_line(2001, 5, 0, 0, 0, 0, CH_SPACE);
    send_line(TEXT_LEN);
    fill_line(2001, 5, 32, 0, 0, 0, CH_SPACE);
    send_line(TEXT_LEN);
    fill_line(2001, 5, 5, 24, 0, 0, CH_SPACE);
    send_line(TEXT_LEN);
    fill_line(2001, 5, 5, 0, 60, 0, CH_SPACE);
    send_line(TEXT_LEN);
    fill_line(2001, 5, 5, 0, 0, 61, CH_SPACE);
    send_line(TEXT_LEN);
    fill_line(9999, 99, 99, 99, 99, 99, CH_SPACE);
    send_line(TEXT_LEN);

    // Bad separators and characters just outside the digit range
    fill_line(2010, 6, 15, 10, 20, 30, CH_SPACE);
    line_buf[POS_DASH_A] = CH_SLASH;
    send_line(TEXT_LEN);
    fill_line(2010, 6, 15, 10, 20, 30, CH_SPACE);
    line_buf[POS_COLON_B] = CH_DASH;
    send_line(TEXT_LEN);
    fill_line(2010, 6, 15, 10, 20, 30, CH_SPACE);
    line_buf[8] = CH_SLASH;
    line_buf[9] = CH_LOW_A;
    line_buf[18] = CH_COLON;
    send_line(TEXT_LEN);

    // Early end at the first and last positions and at the gap
    push_char(CH_NUL, 1'b1);
    fill_line(2010, 6, 15, 10, 20, 30, CH_SPACE);
    send_line(POS_GAP);
    push_char(CH_NUL, 1'b0);
    send_line(POS_LAST);
    push_char(CH_NUL, 1'b0);

    // Restart mid-string, then trailing characters after a full string
    send_line(8);
    fill_line(2038, 1, 19, 3, 14, 8, CH_SPACE);
    send_line(TEXT_LEN);
    repeat (5) push_char(8'($urandom_range(0, 255)), 1'b0);

    drain_results();

    // Random part: mostly well-formed strings with random content
    while (chars_sent < TOTAL_CHARS) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        fill_random_line();
        if ($urandom_range(0, 9) == 0)
          line_buf[$urandom_range(0, POS_LAST)] = 8'($urandom_range(1, 255));
        send_line(TEXT_LEN);
        if ($urandom_range(0, 9) == 0)
          repeat ($urandom_range(1, 4)) push_char(8'($urandom_range(0, 255)), 1'b0);
      end else if (kind < 80) begin
        fill_random_line();
        len = $urandom_range(0, POS_LAST);
        send_line(len);
        push_char(CH_NUL, len == 0);
      end else if (kind < 88) begin
        fill_random_line();
        send_line($urandom_range(1, POS_LAST));
      end else if (kind < 95) begin
        foreach (line_buf[i]) line_buf[i] = 8'($urandom_range(1, 255));
        send_line(TEXT_LEN);
      end else begin
        repeat ($urandom_range(1, 3)) push_char(8'($urandom_range(0, 255)), 1'b0);
      end
      if (strings_sent == 40) drain_results();
    end

    // Wait for the tail, then settle
    char_if.valid <= 1'b0;
    while (sb.stamp_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    sb.flush_missing();

    $display("Sent %0d characters in %0d strings; checked %0d results, %0d valid stamps.",
             chars_sent, strings_sent, sb.checked, sb.good_stamps);
    $display("Mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

@@ datetime_text_to_unix_seconds.f @@
rtl/core/dttu_pkg.sv
rtl/core/dttu_if.sv
rtl/core/dttu_front.sv
rtl/core/dttu_fifo.sv
rtl/core/dttu_back.sv
rtl/core/datetime_text_to_unix_seconds.sv
sim/tb_datetime_text_to_unix_seconds.sv
